// ===== rtl/core/iff_pkg.sv =====
`timescale 1ns / 1ps
package iff_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned DigMax = 20;
  localparam int unsigned DigW   = 5;

  typedef enum logic [1:0] {
    REQ_SDEC = 2'd0,
    REQ_UDEC = 2'd1,
    REQ_HEX  = 2'd2,
    REQ_HEX3 = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    PAD_LEFT  = 2'd0,
    PAD_RIGHT = 2'd1,
    PAD_ZERO  = 2'd2,
    PAD_LEFT3 = 2'd3
  } pad_mode_e;

  // classified item handed from the front to the back end
  typedef struct packed {
    logic              is_hex;
    logic              neg;
    logic [ValueW-1:0] mag;
    logic [1:0]        pad_mode;
    logic [3:0]        width;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PAD_L,
    ST_SIGN,
    ST_ZERO,
    ST_DIG,
    ST_PAD_R
  } back_state_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChMinus = 8'd45;
  localparam logic [7:0] ChZero  = 8'd48;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] r;
    begin
      if (d < 4'd10) r = ChZero + {4'd0, d};
      else r = 8'd87 + {4'd0, d};
      return r;
    end
  endfunction

endpackage

// ===== rtl/core/iff_front.sv =====
`timescale 1ns / 1ps
module iff_front #(
  parameter int unsigned WIDTH_LIMIT = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [1:0]       req_type_i,
  input  logic [63:0]      value_i,
  input  logic [1:0]       pad_mode_i,
  input  logic [3:0]       min_width_i,
  output logic             job_valid_o,
  input  logic             job_take_i,
  output iff_pkg::job_t    job_o
);

  localparam logic [3:0] Lim = 4'(WIDTH_LIMIT > 15 ? 15 : WIDTH_LIMIT);

  // two-entry queue between front and back
  iff_pkg::job_t q_q [2];
  logic          rd_q, wr_q;
  logic [1:0]    cnt_q;
  iff_pkg::job_t job_d;
  logic          acc;

  always_comb begin
    job_d.is_hex   = req_type_i[1];
    job_d.neg      = (req_type_i == iff_pkg::REQ_SDEC) && value_i[63];
    job_d.mag      = job_d.neg ? (64'd0 - value_i) : value_i;
    job_d.pad_mode = pad_mode_i;
    job_d.width    = (min_width_i > Lim) ? Lim : min_width_i;
  end

  assign full_o      = cnt_q[1];
  assign acc         = push_i && !full_o;
  assign job_valid_o = cnt_q != 2'd0;
  assign job_o       = q_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (acc) q_q[wr_q] <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (acc) wr_q <= ~wr_q;
      if (job_take_i && job_valid_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(acc) - 2'(job_take_i && job_valid_o);
    end
  end

`ifndef ASSERT_OFF
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  a_no_take_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take_i |-> job_valid_o) else $error("take from empty queue");
  a_width_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> job_o.width <= Lim) else $error("width not saturated");
`endif

endmodule

// ===== rtl/core/iff_back.sv =====
`timescale 1ns / 1ps
module iff_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_take_o,
  input  iff_pkg::job_t job_i,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [7:0]    char_out_o,
  output logic          last_char_o
);

  localparam logic [63:0] Recip10 = 64'hCCCC_CCCC_CCCC_CCCD;
  localparam logic [2:0]  PhStep  = 3'd4;

  iff_pkg::back_state_e st_q, st_d;
  logic [63:0] mag_q, mag_d;
  logic [3:0]  dig_q [iff_pkg::DigMax];
  logic [iff_pkg::DigW-1:0] nd_q, nd_d, idx_q, idx_d;
  logic [iff_pkg::DigW-1:0] pad_q, pad_d;
  logic        neg_q, hex_q;
  logic [1:0]  pm_q;
  logic [3:0]  w_q;
  logic        ov_q;
  iff_pkg::char_t ob_q, ob_d;
  logic        ld, emit, dig_we, fire;
  logic [2:0]   ph_q, ph_d;
  logic [127:0] acc_q, acc_d;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0] quo;
  logic [3:0]  rem;
  logic [4:0]  tl;

  // mag / 10 by reciprocal multiply, one 32x32 partial product per cycle;
  // the partial products are accumulated in acc_q, then the digit is written and the value stepped
  always_comb begin
    mul_a = ph_q[0] ? mag_q[63:32] : mag_q[31:0];
    mul_b = ph_q[1] ? Recip10[63:32] : Recip10[31:0];
    pp    = {32'd0, mul_a} * {32'd0, mul_b};
    if (ph_q[0] && ph_q[1]) pp_sh = {pp, 64'd0};
    else if (ph_q[0] || ph_q[1]) pp_sh = {32'd0, pp, 32'd0};
    else pp_sh = {64'd0, pp};
    quo = {3'd0, acc_q[127:67]};
    // remainder is below ten, so the low four bits of mag - quo*10 suffice
    rem = mag_q[3:0] - ({quo[0], 3'd0} + {quo[2:0], 1'b0});
  end

  assign tl = nd_q + 5'(neg_q);
  assign empty_o     = !ov_q;
  assign char_out_o  = ob_q.ch;
  assign last_char_o = ob_q.last;
  assign fire = !ov_q || pop_i;

  always_ff @(posedge clk_i) begin
    if (ld) begin
      mag_q <= job_i.mag; neg_q <= job_i.neg; hex_q <= job_i.is_hex;
      pm_q <= job_i.pad_mode; w_q <= job_i.width;
    end else begin
      mag_q <= mag_d;
    end
    if (dig_we) dig_q[nd_q] <= hex_q ? mag_q[3:0] : rem;
    nd_q <= nd_d; idx_q <= idx_d; pad_q <= pad_d;
    ph_q <= ph_d; acc_q <= acc_d;
    if (emit) ob_q <= ob_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= iff_pkg::ST_IDLE; ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (emit) ov_q <= 1'b1;
      else if (pop_i) ov_q <= 1'b0;
    end
  end

  always_comb begin
    st_d = st_q; mag_d = mag_q; nd_d = nd_q; idx_d = idx_q; pad_d = pad_q;
    ph_d = ph_q; acc_d = acc_q;
    ld = 1'b0; job_take_o = 1'b0; dig_we = 1'b0; emit = 1'b0;
    ob_d = '0;
    case (st_q)
      iff_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          ld = 1'b1; job_take_o = 1'b1; nd_d = '0; st_d = iff_pkg::ST_CONV;
          ph_d = '0; acc_d = '0;
        end
      end
      iff_pkg::ST_CONV: begin
        if (!hex_q && ph_q != PhStep) begin
          acc_d = acc_q + pp_sh;
          ph_d  = ph_q + 3'd1;
        end else begin
          dig_we = 1'b1;
          nd_d = nd_q + 5'd1;
          ph_d = '0;
          acc_d = '0;
          if (hex_q) mag_d = {4'd0, mag_q[63:4]};
          else mag_d = quo;
          // hex stops on even digit count with remaining value zero
          if (hex_q ? (nd_q[0] && mag_d == 64'd0) : (quo == 64'd0)) begin
            idx_d = nd_q;
            pad_d = ({1'b0, w_q} > (nd_q + 5'd1 + 5'(neg_q)))
                  ? 5'({1'b0, w_q} - (nd_q + 5'd1 + 5'(neg_q))) : 5'd0;
            case (pm_q)
              iff_pkg::PAD_RIGHT, iff_pkg::PAD_ZERO: st_d = iff_pkg::ST_SIGN;
              default: st_d = iff_pkg::ST_PAD_L;
            endcase
          end
        end
      end
      iff_pkg::ST_PAD_L: begin
        if (pad_q == 5'd0) st_d = iff_pkg::ST_SIGN;
        else if (fire) begin
          emit = 1'b1; ob_d.ch = iff_pkg::ChSpace; pad_d = pad_q - 5'd1;
        end
      end
      iff_pkg::ST_SIGN: begin
        if (!neg_q) st_d = (pm_q == iff_pkg::PAD_ZERO) ? iff_pkg::ST_ZERO
                                                     : iff_pkg::ST_DIG;
        else if (fire) begin
          emit = 1'b1; ob_d.ch = iff_pkg::ChMinus;
          st_d = (pm_q == iff_pkg::PAD_ZERO) ? iff_pkg::ST_ZERO : iff_pkg::ST_DIG;
        end
      end
      iff_pkg::ST_ZERO: begin
        if (pad_q == 5'd0) st_d = iff_pkg::ST_DIG;
        else if (fire) begin
          emit = 1'b1; ob_d.ch = iff_pkg::ChZero; pad_d = pad_q - 5'd1;
        end
      end
      iff_pkg::ST_DIG: begin
        if (fire) begin
          emit = 1'b1; ob_d.ch = iff_pkg::hex_char(dig_q[idx_q]);
          if (idx_q == 5'd0) begin
            if (pm_q == iff_pkg::PAD_RIGHT && pad_q != 5'd0) begin
              st_d = iff_pkg::ST_PAD_R;
            end else begin
              ob_d.last = 1'b1; st_d = iff_pkg::ST_IDLE;
            end
          end else idx_d = idx_q - 5'd1;
        end
      end
      iff_pkg::ST_PAD_R: begin
        if (fire) begin
          emit = 1'b1; ob_d.ch = iff_pkg::ChSpace; pad_d = pad_q - 5'd1;
          if (pad_q == 5'd1) begin
            ob_d.last = 1'b1; st_d = iff_pkg::ST_IDLE;
          end
        end
      end
      default: st_d = iff_pkg::ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!ov_q || pop_i)) else $error("output overwritten");
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == iff_pkg::ST_CONV |-> nd_q < 5'd20) else $error("digit overflow");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && ob_d.last) |=> st_q == iff_pkg::ST_IDLE) else $error("last mismatch");
  a_tl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == iff_pkg::ST_DIG |-> tl != 5'd0) else $error("empty text");
`endif

endmodule

// ===== rtl/core/integer_field_formatter_unit.sv =====
// Conversion: with the back end idle, an accepted item is converted in full
// (decimal digits by reciprocal multiply, hex digits by shifting) before its
// first character. Throughput: at most one character per cycle while the
// receiver pops; the next item is taken only after the current one's last char.
// Reset: asynchronous active low; clears queue, state and output valid flag.
`timescale 1ns / 1ps
module integer_field_formatter_unit #(
  parameter int unsigned WIDTH_LIMIT = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] value_i,
  input  logic [1:0]  pad_mode_i,
  input  logic [3:0]  min_width_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  char_out_o,
  output logic        last_char_o
);

  logic          jv, jt;
  iff_pkg::job_t job;

  iff_front #(.WIDTH_LIMIT(WIDTH_LIMIT)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .req_type_i, .value_i,
    .pad_mode_i, .min_width_i, .job_valid_o(jv), .job_take_i(jt), .job_o(job)
  );

  iff_back u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_take_o(jt), .job_i(job),
    .empty_o(empty), .pop_i(pop), .char_out_o, .last_char_o
  );

endmodule

// ===== tb/integer_field_formatter_unit_tb.sv =====
`timescale 1ns / 1ps
module integer_field_formatter_unit_tb;

  localparam int unsigned WLimit = 9;
  localparam int unsigned HoldCycles = 300;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } exp_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  req_type_i = '0;
  logic [63:0] value_i = '0;
  logic [1:0]  pad_mode_i = '0;
  logic [3:0]  min_width_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  char_out_o;
  logic        last_char_o;

  exp_char_t   expected_chars[$];
  int          n_errors = 0;
  int          n_items = 0;
  int          n_chars = 0;
  int          pop_idle_pct = 19;
  int          push_idle_pct = 19;
  logic        hold_pop = 1'b0;

  integer_field_formatter_unit #(.WIDTH_LIMIT(WLimit)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .req_type_i(req_type_i), .value_i(value_i), .pad_mode_i(pad_mode_i),
    .min_width_i(min_width_i), .empty(empty), .pop(pop),
    .char_out_o(char_out_o), .last_char_o(last_char_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    return (d < 10) ? 8'd48 + d : 8'd87 + d;
  endfunction

  // Builds the expected text field for one item and queues its characters.
  task automatic format_field(input iff_pkg::req_type_e rt, input logic [63:0] val,
                              input iff_pkg::pad_mode_e pm, input logic [3:0] mw);
    logic [7:0] digs[$];
    logic [7:0] field[$];
    logic [63:0] mag;
    logic [7:0] b;
    logic       neg;
    logic       started;
    int         width;
    int         pad;
    exp_char_t  e;
    mag = val;
    neg = 1'b0;
    width = (mw > WLimit) ? WLimit : mw;
    if (rt == iff_pkg::REQ_SDEC || rt == iff_pkg::REQ_UDEC) begin
      if (rt == iff_pkg::REQ_SDEC && val[63]) begin
        neg = 1'b1;
        mag = -val;
      end
      do begin
        digs.push_front(8'd48 + 8'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
    end else begin
      started = 1'b0;
      for (int i = 7; i >= 0; i--) begin
        b = val[i*8 +: 8];
        if (b != 0 || started || i == 0) begin
          started = 1'b1;
          digs.push_back(hex_digit(b[7:4]));
          digs.push_back(hex_digit(b[3:0]));
        end
      end
    end
    pad = width - (digs.size() + neg);
    if (pad < 0) pad = 0;
    if (pm == iff_pkg::PAD_RIGHT) begin
      if (neg) field.push_back(8'd45);
      foreach (digs[i]) field.push_back(digs[i]);
      repeat (pad) field.push_back(8'd32);
    end else if (pm == iff_pkg::PAD_ZERO) begin
      if (neg) field.push_back(8'd45);
      repeat (pad) field.push_back(8'd48);
      foreach (digs[i]) field.push_back(digs[i]);
    end else begin
      repeat (pad) field.push_back(8'd32);
      if (neg) field.push_back(8'd45);
      foreach (digs[i]) field.push_back(digs[i]);
    end
    foreach (field[i]) begin
      e.ch = field[i];
      e.last = (i == field.size() - 1);
      expected_chars.push_back(e);
    end
  endtask

  // push stays high after an accept only when the next item follows at once
  task automatic send_item(input iff_pkg::req_type_e rt, input logic [63:0] val,
                           input iff_pkg::pad_mode_e pm, input logic [3:0] mw);
    while ($urandom_range(99, 0) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    format_field(rt, val, pm, mw);
    push <= 1'b1;
    req_type_i <= rt;
    value_i <= val;
    pad_mode_i <= pm;
    min_width_i <= mw;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    n_items++;
  endtask

  // Random value with a random magnitude so short and long fields both occur.
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int          nbits;
    v = {$urandom(), $urandom()};
    nbits = $urandom_range(64, 1);
    if (nbits < 64) v = v & ((64'd1 << nbits) - 1);
    if ($urandom_range(3, 0) == 0) v = -v;
    return v;
  endfunction

  // Result checker; pop is redrawn each cycle unless hold_pop forces it low.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        n_chars++;
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected char expected none actual %h last %b",
                   $realtime, char_out_o, last_char_o);
          n_errors++;
        end else begin
          if (char_out_o !== expected_chars[0].ch ||
              last_char_o !== expected_chars[0].last) begin
            $display("%0t: mismatch expected %h/%b actual %h/%b", $realtime,
                     expected_chars[0].ch, expected_chars[0].last,
                     char_out_o, last_char_o);
            n_errors++;
          end
          void'(expected_chars.pop_front());
        end
      end
      if (hold_pop) begin
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99, 0) >= pop_idle_pct);
      end
    end
  end

  task automatic test_extremes();
    logic [63:0] vals[8];
    vals = '{64'd0, 64'd9, 64'd10, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
             64'h7fff_ffff_ffff_ffff, 64'h0000_0100_0000_0000, 64'd255};
    foreach (vals[i])
      send_item(iff_pkg::req_type_e'(i % 4), vals[i],
                iff_pkg::pad_mode_e'((i / 2) % 4), 4'(i + 2));
  endtask

  task automatic test_modes();
    for (int r = 0; r < 4; r++)
      for (int p = 0; p < 4; p++)
        send_item(iff_pkg::req_type_e'(r), 64'hffff_ffff_ffff_fff3 + r,
                  iff_pkg::pad_mode_e'(p), 4'(p * 5));
    send_item(iff_pkg::REQ_SDEC, 64'h8000_0000_0000_0000, iff_pkg::PAD_ZERO, 4'd15);
  endtask

  task automatic test_backpressure();
    // receiver holds off in its own process while items keep coming
    fork
      begin
        hold_pop = 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_pop = 1'b0;
      end
    join_none
    repeat (10) send_item(iff_pkg::req_type_e'($urandom_range(3, 0)), rand_value(),
                          iff_pkg::pad_mode_e'($urandom_range(3, 0)),
                          4'($urandom_range(15, 0)));
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      // a long run without idling on either side
      if (i == count / 2) begin
        pop_idle_pct = 0;
        push_idle_pct = 0;
      end else if (i == count / 2 + 60) begin
        pop_idle_pct = 19;
        push_idle_pct = 19;
      end
      send_item(iff_pkg::req_type_e'($urandom_range(3, 0)), rand_value(),
                iff_pkg::pad_mode_e'($urandom_range(3, 0)), 4'($urandom_range(15, 0)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_modes();
    test_backpressure();
    test_random(280);
    push <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Formatted %0d items into %0d chars: signed/unsigned decimal and hex,",
             n_items, n_chars);
    $display("all padding modes, widths 0-15, with output stalls and a full queue.");
    if (n_errors == 0 && expected_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
